>>> rtl/albs_pkg.sv
// ----------------------------------------------------------------------------
// ALU and barrel shifter package
// Opcodes, shift types and the shifter result bundle.
// ----------------------------------------------------------------------------
package albs_pkg;

    localparam int unsigned DataW = 32;
    localparam int unsigned AmtW  = 8;

    typedef enum logic [3:0] {
        OP_AND = 4'd0,
        OP_EOR = 4'd1,
        OP_SUB = 4'd2,
        OP_RSB = 4'd3,
        OP_ADD = 4'd4,
        OP_ADC = 4'd5,
        OP_SBC = 4'd6,
        OP_RSC = 4'd7,
        OP_TST = 4'd8,
        OP_TEQ = 4'd9,
        OP_CMP = 4'd10,
        OP_CMN = 4'd11,
        OP_ORR = 4'd12,
        OP_MOV = 4'd13,
        OP_BIC = 4'd14,
        OP_MVN = 4'd15
    } alu_op_t;

    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } shift_t;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             carry;
    } shift_res_t;

endpackage

>>> rtl/albs_shifter.sv
// ----------------------------------------------------------------------------
// Barrel shifter
// Shifts or rotates operand B and produces the shifter carry out.
// ----------------------------------------------------------------------------
module albs_shifter
    import albs_pkg::*;
(
    input  logic [DataW-1:0] operand_b,
    input  logic             imm_form,
    input  logic [1:0]       shift_type,
    input  logic [AmtW-1:0]  shift_amount,
    input  logic             amount_from_register,
    input  logic             carry_in,
    output shift_res_t       shifted
);

    logic [AmtW:0]      eff_amt;
    logic [4:0]         rot_amt;
    logic [2*DataW-1:0] rot_wide;
    logic [DataW-1:0]   rot_val;
    logic [DataW:0]     lsl_wide;
    logic [DataW:0]     lsr_wide;
    logic [DataW:0]     asr_wide;
    logic               sign;
    logic               amt_zero;

    always_comb
    begin
        amt_zero = (shift_amount == '0);
        eff_amt  = amt_zero ? (AmtW+1)'(DataW) : {1'b0, shift_amount};
        rot_amt  = shift_amount[4:0];
        rot_wide = {operand_b, operand_b} >> rot_amt;
        rot_val  = rot_wide[DataW-1:0];
        sign     = operand_b[DataW-1];
        lsl_wide = {1'b0, operand_b} << eff_amt[4:0];
        lsr_wide = {operand_b, 1'b0} >> eff_amt[4:0];
        asr_wide = (DataW+1)'($signed({operand_b, 1'b0}) >>> eff_amt[4:0]);

        shifted.value = operand_b;
        shifted.carry = carry_in;

        if (imm_form)
        begin
            if (!amt_zero)
            begin
                shifted.value = rot_val;
                shifted.carry = rot_val[DataW-1];
            end
        end
        else if (amt_zero && (amount_from_register || shift_type == SH_LSL))
        begin
            shifted.value = operand_b;
            shifted.carry = carry_in;
        end
        else if (amt_zero && shift_type == SH_ROR)
        begin
            shifted.value = {carry_in, operand_b[DataW-1:1]};
            shifted.carry = operand_b[0];
        end
        else
        begin
            unique case (shift_t'(shift_type))
                SH_LSL:
                begin
                    if (eff_amt < (AmtW+1)'(DataW))
                    begin
                        shifted.value = lsl_wide[DataW-1:0];
                        shifted.carry = lsl_wide[DataW];
                    end
                    else
                    begin
                        shifted.value = '0;
                        shifted.carry = (eff_amt == (AmtW+1)'(DataW)) ? operand_b[0] : 1'b0;
                    end
                end
                SH_LSR:
                begin
                    if (eff_amt < (AmtW+1)'(DataW))
                    begin
                        shifted.value = lsr_wide[DataW:1];
                        shifted.carry = lsr_wide[0];
                    end
                    else
                    begin
                        shifted.value = '0;
                        shifted.carry = (eff_amt == (AmtW+1)'(DataW)) ? sign : 1'b0;
                    end
                end
                SH_ASR:
                begin
                    if (eff_amt < (AmtW+1)'(DataW))
                    begin
                        shifted.value = asr_wide[DataW:1];
                        shifted.carry = asr_wide[0];
                    end
                    else
                    begin
                        shifted.value = {DataW{sign}};
                        shifted.carry = sign;
                    end
                end
                SH_ROR:
                begin
                    shifted.value = rot_val;
                    shifted.carry = rot_val[DataW-1];
                end
                default:
                begin
                    shifted.value = operand_b;
                    shifted.carry = carry_in;
                end
            endcase
        end
    end

endmodule

>>> rtl/alu_with_barrel_shifter_top.sv
// ----------------------------------------------------------------------------
// ALU with barrel shifter
// Data-processing execute stage: shift operand B, run AND..MVN, keep NZCV.
// ----------------------------------------------------------------------------
// Input beats are registered in the input stage, results in the output stage.
// Throughput: one beat per cycle unless the output stalls; the flag register
// feeds the next item directly, so back-to-back items see each other's carry.
// Reset: clears both stage valid bits and the NZCV flags to zero.
// ----------------------------------------------------------------------------
module alu_with_barrel_shifter_top
    import albs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             op_valid,
    output logic             op_stall,
    input  logic [3:0]       alu_op,
    input  logic [DataW-1:0] operand_a,
    input  logic [DataW-1:0] operand_b,
    input  logic             imm_form,
    input  logic [1:0]       shift_type,
    input  logic [AmtW-1:0]  shift_amount,
    input  logic             amount_from_register,
    input  logic             set_flags,
    output logic             res_valid,
    input  logic             res_stall,
    output logic [DataW-1:0] result,
    output logic             writes_result,
    output logic             flag_n,
    output logic             flag_z,
    output logic             flag_c,
    output logic             flag_v
);

    logic             in_vld_reg;
    logic [3:0]       op_reg;
    logic [DataW-1:0] a_reg;
    logic [DataW-1:0] b_reg;
    logic             imm_reg;
    logic [1:0]       type_reg;
    logic [AmtW-1:0]  amt_reg;
    logic             from_reg_reg;
    logic             s_reg;

    logic             out_vld_reg;
    logic [DataW-1:0] result_reg;
    logic             writes_reg;
    logic [3:0]       flags_reg;
    logic [3:0]       flags_next;

    logic             accept;
    logic             advance;
    shift_res_t       shifted;

    logic [DataW-1:0] op2;
    logic [DataW-1:0] add_x;
    logic [DataW-1:0] add_y;
    logic             add_cin;
    logic [DataW:0]   sum;
    logic [DataW-1:0] alu_res;
    logic             alu_c;
    logic             alu_v;
    logic             arith;
    logic             writes;

    assign advance  = in_vld_reg && (!out_vld_reg || !res_stall);
    assign op_stall = in_vld_reg && !advance;
    assign accept   = op_valid && !op_stall;

    albs_shifter u_shifter (
        .operand_b            (b_reg),
        .imm_form             (imm_reg),
        .shift_type           (type_reg),
        .shift_amount         (amt_reg),
        .amount_from_register (from_reg_reg),
        .carry_in             (flags_reg[1]),
        .shifted              (shifted)
    );

    always_comb
    begin
        op2     = shifted.value;
        add_x   = a_reg;
        add_y   = op2;
        add_cin = 1'b0;
        arith   = 1'b0;
        writes  = 1'b1;
        unique case (alu_op_t'(op_reg))
            OP_SUB, OP_CMP:
            begin
                add_y   = ~op2;
                add_cin = 1'b1;
                arith   = 1'b1;
            end
            OP_RSB:
            begin
                add_x   = op2;
                add_y   = ~a_reg;
                add_cin = 1'b1;
                arith   = 1'b1;
            end
            OP_ADD, OP_CMN:
            begin
                arith = 1'b1;
            end
            OP_ADC:
            begin
                add_cin = flags_reg[1];
                arith   = 1'b1;
            end
            OP_SBC:
            begin
                add_y   = ~op2;
                add_cin = flags_reg[1];
                arith   = 1'b1;
            end
            OP_RSC:
            begin
                add_x   = op2;
                add_y   = ~a_reg;
                add_cin = flags_reg[1];
                arith   = 1'b1;
            end
            default:
            begin
                arith = 1'b0;
            end
        endcase
        if (op_reg == OP_TST || op_reg == OP_TEQ || op_reg == OP_CMP || op_reg == OP_CMN)
        begin
            writes = 1'b0;
        end

        sum = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_cin};

        unique case (alu_op_t'(op_reg))
            OP_AND, OP_TST: alu_res = a_reg & op2;
            OP_EOR, OP_TEQ: alu_res = a_reg ^ op2;
            OP_ORR:         alu_res = a_reg | op2;
            OP_MOV:         alu_res = op2;
            OP_BIC:         alu_res = a_reg & ~op2;
            OP_MVN:         alu_res = ~op2;
            default:        alu_res = sum[DataW-1:0];
        endcase

        alu_c = arith ? sum[DataW] : shifted.carry;
        alu_v = arith ? ((~(add_x[DataW-1] ^ add_y[DataW-1])) &
                         (add_x[DataW-1] ^ sum[DataW-1]))
                      : flags_reg[0];

        flags_next = flags_reg;
        if (s_reg || !writes)
        begin
            flags_next = {alu_res[DataW-1], (alu_res == '0), alu_c, alu_v};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            flags_reg   <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
                flags_reg   <= flags_next;
            end
            else if (!res_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= alu_op;
            a_reg        <= operand_a;
            b_reg        <= operand_b;
            imm_reg      <= imm_form;
            type_reg     <= shift_type;
            amt_reg      <= shift_amount;
            from_reg_reg <= amount_from_register;
            s_reg        <= set_flags;
        end
        if (advance)
        begin
            result_reg <= alu_res;
            writes_reg <= writes;
        end
    end

    assign res_valid     = out_vld_reg;
    assign result        = result_reg;
    assign writes_result = writes_reg;
    assign flag_n        = flags_reg[3];
    assign flag_z        = flags_reg[2];
    assign flag_c        = flags_reg[1];
    assign flag_v        = flags_reg[0];

`ifndef SYNTHESIS
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(flags_reg))
        else $error("flags changed without an advancing item");

    a_cmp_flag_z: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !writes_result |-> flag_z == (result == '0))
        else $error("compare or test beat with inconsistent Z flag");

    a_cmp_flag_n: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !writes_result |-> flag_n == result[DataW-1])
        else $error("compare or test beat with inconsistent N flag");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        op_stall |-> in_vld_reg && out_vld_reg && res_stall)
        else $error("input stalled while the pipeline can move");

    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid)
        else $error("advanced item did not reach the output");
`endif

endmodule

>>> tb/sv/tb_alu_with_barrel_shifter_top.sv
// ----------------------------------------------------------------------------
// Testbench: ALU with barrel shifter
// Drives directed and random data-processing beats through the execute stage,
// predicts result, write enable and NZCV for every accepted beat, and checks
// each result beat in order. Random stall bursts on both sides, a long result
// hold-off and a full drain exercise the handshake.
// ----------------------------------------------------------------------------
module tb_alu_with_barrel_shifter_top
    import albs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IdleLimit = 2000;
    localparam int unsigned HoldCycles = 60;
    localparam int unsigned MaxPrinted = 20;

    typedef struct {
        alu_op_t          alu_op;
        logic [DataW-1:0] operand_a;
        logic [DataW-1:0] operand_b;
        logic             imm_form;
        shift_t           shift_type;
        logic [AmtW-1:0]  shift_amount;
        logic             amount_from_register;
        logic             set_flags;
    } op_beat_t;

    typedef struct {
        logic [DataW-1:0] result;
        logic             writes_result;
        logic             flag_n;
        logic             flag_z;
        logic             flag_c;
        logic             flag_v;
    } res_beat_t;

    class alu_scoreboard;
        logic [3:0] nzcv;
        res_beat_t  pending_results[$];
        int         errors;

        function new();
            nzcv = 4'b0000;
            errors = 0;
        endfunction

        function logic [DataW-1:0] rotr(logic [DataW-1:0] v, logic [4:0] r);
            if (r == 5'd0)
                return v;
            return (v >> r) | (v << (32 - r));
        endfunction

        // {carry out, shifted operand}
        function logic [DataW:0] shift_operand(op_beat_t b, logic cin);
            logic [DataW-1:0] v;
            logic [DataW-1:0] sra;
            logic [AmtW-1:0]  n;
            v = b.operand_b;
            n = b.shift_amount;
            if (b.imm_form)
            begin
                if (n == 0)
                    return {cin, v};
                v = rotr(v, n[4:0]);
                return {v[31], v};
            end
            if (n == 0)
            begin
                if (b.amount_from_register || b.shift_type == SH_LSL)
                    return {cin, v};
                if (b.shift_type == SH_ROR)
                    return {v[0], cin, v[31:1]};
                n = 8'd32;
            end
            case (b.shift_type)
                SH_LSL:
                    if (n < 32)
                        return {v[32 - n], v << n};
                    else
                        return {(n == 32) && v[0], 32'd0};
                SH_LSR:
                    if (n < 32)
                        return {v[n - 1], v >> n};
                    else
                        return {(n == 32) && v[31], 32'd0};
                SH_ASR:
                    if (n >= 32)
                        return {v[31], {32{v[31]}}};
                    else
                    begin
                        sra = $signed(v) >>> n;
                        return {v[n - 1], sra};
                    end
                default:
                begin
                    v = rotr(v, n[4:0]);
                    return {v[31], v};
                end
            endcase
        endfunction

        function void add_carry(logic [DataW-1:0] x, logic [DataW-1:0] y, logic ci,
                                output logic [DataW-1:0] r, output logic c,
                                output logic v);
            logic [DataW:0] sum;
            sum = {1'b0, x} + {1'b0, y} + {32'd0, ci};
            r = sum[31:0];
            c = sum[32];
            v = ~(x[31] ^ y[31]) & (x[31] ^ r[31]);
        endfunction

        function res_beat_t predict_execute(op_beat_t b);
            res_beat_t        e;
            logic [DataW:0]   sh;
            logic [DataW-1:0] a;
            logic [DataW-1:0] op2;
            logic [DataW-1:0] r;
            logic             cin;
            logic             c;
            logic             v;
            logic             arith;
            logic             writes;
            cin = nzcv[1];
            sh = shift_operand(b, cin);
            a = b.operand_a;
            op2 = sh[31:0];
            c = sh[32];
            v = 1'b0;
            arith = 1'b1;
            writes = !(b.alu_op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
            case (b.alu_op)
                OP_SUB, OP_CMP: add_carry(a, ~op2, 1'b1, r, c, v);
                OP_RSB:         add_carry(op2, ~a, 1'b1, r, c, v);
                OP_ADD, OP_CMN: add_carry(a, op2, 1'b0, r, c, v);
                OP_ADC:         add_carry(a, op2, cin, r, c, v);
                OP_SBC:         add_carry(a, ~op2, cin, r, c, v);
                OP_RSC:         add_carry(op2, ~a, cin, r, c, v);
                default:
                begin
                    arith = 1'b0;
                    case (b.alu_op)
                        OP_AND, OP_TST: r = a & op2;
                        OP_EOR, OP_TEQ: r = a ^ op2;
                        OP_ORR:         r = a | op2;
                        OP_MOV:         r = op2;
                        OP_BIC:         r = a & ~op2;
                        default:        r = ~op2;
                    endcase
                end
            endcase
            if (b.set_flags || !writes)
                nzcv = {r[31], r == 32'd0, c, arith ? v : nzcv[0]};
            e.result = r;
            e.writes_result = writes;
            {e.flag_n, e.flag_z, e.flag_c, e.flag_v} = nzcv;
            return e;
        endfunction

        function void note_op(op_beat_t b);
            pending_results.push_back(predict_execute(b));
        endfunction

        function int pending_count();
            return pending_results.size();
        endfunction

        task report(string what);
            errors++;
            if (errors <= MaxPrinted)
                $display("mismatch at %0t: %s", $realtime, what);
        endtask

        task check_result(res_beat_t got);
            res_beat_t e;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result beat %h with nothing outstanding", got.result));
                return;
            end
            e = pending_results.pop_front();
            if (got.result !== e.result)
                report($sformatf("result %h, want %h", got.result, e.result));
            if (got.writes_result !== e.writes_result)
                report($sformatf("writes_result %b, want %b", got.writes_result,
                                 e.writes_result));
            if (got.flag_n !== e.flag_n)
                report($sformatf("flag_n %b, want %b", got.flag_n, e.flag_n));
            if (got.flag_z !== e.flag_z)
                report($sformatf("flag_z %b, want %b", got.flag_z, e.flag_z));
            if (got.flag_c !== e.flag_c)
                report($sformatf("flag_c %b, want %b", got.flag_c, e.flag_c));
            if (got.flag_v !== e.flag_v)
                report($sformatf("flag_v %b, want %b", got.flag_v, e.flag_v));
        endtask
    endclass

    logic             clk;
    logic             rst_n;
    logic             op_valid;
    logic             op_stall;
    logic [3:0]       alu_op;
    logic [DataW-1:0] operand_a;
    logic [DataW-1:0] operand_b;
    logic             imm_form;
    logic [1:0]       shift_type;
    logic [AmtW-1:0]  shift_amount;
    logic             amount_from_register;
    logic             set_flags;
    logic             res_valid;
    logic             res_stall;
    logic [DataW-1:0] result;
    logic             writes_result;
    logic             flag_n;
    logic             flag_z;
    logic             flag_c;
    logic             flag_v;

    bit tx_idle_en;
    bit rx_idle_en;
    bit hold_req;
    int unsigned quiet_cycles;

    alu_scoreboard sb = new();

    alu_with_barrel_shifter_top uut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .op_valid             (op_valid),
        .op_stall             (op_stall),
        .alu_op               (alu_op),
        .operand_a            (operand_a),
        .operand_b            (operand_b),
        .imm_form             (imm_form),
        .shift_type           (shift_type),
        .shift_amount         (shift_amount),
        .amount_from_register (amount_from_register),
        .set_flags            (set_flags),
        .res_valid            (res_valid),
        .res_stall            (res_stall),
        .result               (result),
        .writes_result        (writes_result),
        .flag_n               (flag_n),
        .flag_z               (flag_z),
        .flag_c               (flag_c),
        .flag_v               (flag_v)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic op_beat_t mk(alu_op_t op, logic [DataW-1:0] a, logic [DataW-1:0] b,
                                    logic imm, shift_t sh, logic [AmtW-1:0] amt,
                                    logic from_reg, logic s);
        op_beat_t x;
        x.alu_op = op;
        x.operand_a = a;
        x.operand_b = b;
        x.imm_form = imm;
        x.shift_type = sh;
        x.shift_amount = amt;
        x.amount_from_register = from_reg;
        x.set_flags = s;
        return x;
    endfunction

    function automatic logic [DataW-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic op_beat_t random_beat();
        op_beat_t x;
        x.alu_op = alu_op_t'($urandom_range(0, 15));
        x.operand_a = pick_word();
        x.imm_form = ($urandom_range(0, 3) == 0);
        if (x.imm_form && $urandom_range(0, 1) == 0)
            x.operand_b = $urandom_range(0, 255);
        else
            x.operand_b = pick_word();
        x.shift_type = shift_t'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0)
            x.shift_amount = AmtW'($urandom_range(0, 255));
        else
            x.shift_amount = AmtW'($urandom_range(0, 33));
        x.amount_from_register = 1'($urandom_range(0, 1));
        x.set_flags = 1'($urandom_range(0, 1));
        return x;
    endfunction

    task automatic send_op(input op_beat_t b);
        int gap;
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 3);
            @(negedge clk);
            op_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        op_valid             <= 1'b1;
        alu_op               <= b.alu_op;
        operand_a            <= b.operand_a;
        operand_b            <= b.operand_b;
        imm_form             <= b.imm_form;
        shift_type           <= b.shift_type;
        shift_amount         <= b.shift_amount;
        amount_from_register <= b.amount_from_register;
        set_flags            <= b.set_flags;
        do
            @(posedge clk);
        while (op_stall);
    endtask

    task automatic drain_results();
        @(negedge clk);
        op_valid <= 1'b0;
        while (sb.pending_count() != 0)
            @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_op(random_beat());
    endtask

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin : result_sink
        int n;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_stall <= 1'b1;
                repeat (HoldCycles) @(negedge clk);
                res_stall <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 4) == 0)
            begin
                n = $urandom_range(1, 3);
                res_stall <= 1'b1;
                repeat (n) @(negedge clk);
                res_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        op_beat_t  ib;
        res_beat_t rb;
        if (rst_n && op_valid && !op_stall)
        begin
            ib.alu_op = alu_op_t'(alu_op);
            ib.operand_a = operand_a;
            ib.operand_b = operand_b;
            ib.imm_form = imm_form;
            ib.shift_type = shift_t'(shift_type);
            ib.shift_amount = shift_amount;
            ib.amount_from_register = amount_from_register;
            ib.set_flags = set_flags;
            sb.note_op(ib);
        end
        if (rst_n && res_valid && !res_stall)
        begin
            rb.result = result;
            rb.writes_result = writes_result;
            rb.flag_n = flag_n;
            rb.flag_z = flag_z;
            rb.flag_c = flag_c;
            rb.flag_v = flag_v;
            sb.check_result(rb);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (op_valid && !op_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= IdleLimit)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        rst_n = 1'b0;
        op_valid = 1'b0;
        res_stall = 1'b0;
        alu_op = OP_AND;
        operand_a = '0;
        operand_b = '0;
        imm_form = 1'b0;
        shift_type = SH_LSL;
        shift_amount = '0;
        amount_from_register = 1'b0;
        set_flags = 1'b0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        hold_req = 1'b0;
        quiet_cycles = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_op(mk(OP_MOV, 32'h0, 32'hFFFF_FFFF, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_ADD, 32'hFFFF_FFFF, 32'h1, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_ADC, 32'h7FFF_FFFF, 32'h0, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_SUB, 32'h0, 32'h1, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_RSB, 32'h5, 32'h3, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_SBC, 32'h8000_0000, 32'h1, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_RSC, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, SH_LSL, 8'd0, 1'b1, 1'b1));
        send_op(mk(OP_AND, 32'hFFFF_FFFF, 32'h8000_0001, 1'b0, SH_LSL, 8'd32, 1'b1, 1'b1));
        send_op(mk(OP_EOR, 32'h0, 32'hFFFF_FFFF, 1'b0, SH_LSL, 8'd33, 1'b1, 1'b1));
        send_op(mk(OP_ORR, 32'h0, 32'h8000_0000, 1'b0, SH_LSR, 8'd32, 1'b1, 1'b1));
        send_op(mk(OP_BIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, SH_LSR, 8'd200, 1'b1, 1'b1));
        send_op(mk(OP_MVN, 32'h0, 32'h8000_0000, 1'b0, SH_ASR, 8'd32, 1'b1, 1'b1));
        send_op(mk(OP_MOV, 32'h0, 32'h8000_0000, 1'b0, SH_ASR, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_MOV, 32'h0, 32'h0000_0001, 1'b0, SH_LSR, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_MOV, 32'h0, 32'h0000_0003, 1'b0, SH_ROR, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_MOV, 32'h0, 32'h1234_5678, 1'b0, SH_ROR, 8'd0, 1'b1, 1'b1));
        send_op(mk(OP_MOV, 32'h0, 32'h8000_0001, 1'b0, SH_ROR, 8'd64, 1'b1, 1'b1));
        send_op(mk(OP_MOV, 32'h0, 32'h0000_00FF, 1'b1, SH_LSL, 8'd0, 1'b0, 1'b1));
        send_op(mk(OP_MOV, 32'h0, 32'h0000_00FF, 1'b1, SH_ASR, 8'd8, 1'b1, 1'b1));
        send_op(mk(OP_TST, 32'h0, 32'hFFFF_FFFF, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b0));
        send_op(mk(OP_TEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b0));
        send_op(mk(OP_CMP, 32'h1, 32'h2, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b0));
        send_op(mk(OP_CMN, 32'h7FFF_FFFF, 32'h1, 1'b0, SH_LSL, 8'd0, 1'b0, 1'b0));
        send_op(mk(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, SH_LSL, 8'd31, 1'b0, 1'b0));
        send_op(mk(OP_MOV, 32'h0, 32'hFFFF_FFFF, 1'b0, SH_ASR, 8'd255, 1'b1, 1'b1));

        send_random(600);
        hold_req = 1'b1;
        send_random(100);
        drain_results();
        send_random(500);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        send_random(300);

        drain_results();
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_count() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
